FILE: rtl/core/interval_slot_allocator_with_quotas_unit_defines.svh
// ----------------------------------------------------------------------------
// Interval slot allocator assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SLOT_ALLOCATOR_WITH_QUOTAS_UNIT_DEFINES_SVH
`define INTERVAL_SLOT_ALLOCATOR_WITH_QUOTAS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ISAQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ISAQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ISAQ_ASSERT(lbl, prop, msg)
`define ISAQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/isaq_pkg.sv
// ----------------------------------------------------------------------------
// Interval slot allocator package
// Transfer types, request kinds and status codes.
// ----------------------------------------------------------------------------
package isaq_pkg;

   localparam logic REQ_SET_QUOTA = 1'b0;
   localparam logic REQ_RESERVE   = 1'b1;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_INTERVAL = 3'd1,
      ST_BAD_CATEGORY = 3'd2,
      ST_NO_QUOTA     = 3'd3,
      ST_CONFLICT     = 3'd4,
      ST_FULL_OR_SET  = 3'd5
   } status_type;

   typedef struct packed {
      logic       req_type;
      logic [4:0] start_hour;
      logic [4:0] end_hour;
      logic [4:0] category_id;
      logic [7:0] quota_value;
   } req_type_t_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  status_code;
      logic [4:0]  free_slot_count;
      logic [23:0] occupancy_map;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic load;
   } upd_type;

endpackage

FILE: rtl/core/isaq_eval.sv
// ----------------------------------------------------------------------------
// Interval slot allocator evaluation
// Checks one item against the map, free count and quota and forms the result.
// ----------------------------------------------------------------------------
module isaq_eval #(
   parameter int NUM_SLOTS      = 24,
   parameter int NUM_CATEGORIES = 16,
   parameter int QUOTA_WIDTH    = 8,
   parameter int FREE_W         = 5
) (
   input  isaq_pkg::req_type_t_type req,
   input  logic [QUOTA_WIDTH-1:0]   quota_rd,
   input  logic [NUM_SLOTS-1:0]     map,
   input  logic [FREE_W-1:0]        free,
   output isaq_pkg::rsp_type        rsp,
   output isaq_pkg::upd_type        upd,
   output logic [NUM_SLOTS-1:0]     map_next,
   output logic [FREE_W-1:0]        free_next
);

   localparam int CNT_W = (FREE_W > 5) ? FREE_W : 5;

   logic                 cat_ok;
   logic                 span_ok;
   logic                 conflict;
   logic [NUM_SLOTS-1:0] mask;
   logic [4:0]           len;
   logic [CNT_W-1:0]     free_ext;
   logic [CNT_W-1:0]     len_ext;
   logic [CNT_W-1:0]     diff;
   isaq_pkg::status_type status;

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         mask[i] = (7'(i) >= {2'b00, req.start_hour}) && (7'(i) < {2'b00, req.end_hour});
      end
   end

   assign cat_ok   = (req.category_id != 5'd0)
                  && ({4'b0000, req.category_id} <= 9'(NUM_CATEGORIES));
   assign span_ok  = (req.start_hour < req.end_hour)
                  && ({2'b00, req.end_hour} <= 7'(NUM_SLOTS));
   assign conflict = |(map & mask);
   assign len      = req.end_hour - req.start_hour;
   assign free_ext = CNT_W'(free);
   assign len_ext  = CNT_W'(len);
   assign diff     = (free_ext >= len_ext) ? (free_ext - len_ext) : '0;

   always_comb begin
      upd.take = 1'b0;
      upd.load = 1'b0;
      status   = isaq_pkg::ST_OK;
      priority if (req.req_type == isaq_pkg::REQ_SET_QUOTA) begin
         if (cat_ok) begin
            upd.load = 1'b1;
            status   = isaq_pkg::ST_FULL_OR_SET;
         end else begin
            status   = isaq_pkg::ST_BAD_CATEGORY;
         end
      end else if (free == '0) begin
         status = isaq_pkg::ST_FULL_OR_SET;
      end else if (!span_ok) begin
         status = isaq_pkg::ST_BAD_INTERVAL;
      end else if (!cat_ok) begin
         status = isaq_pkg::ST_BAD_CATEGORY;
      end else if (quota_rd == '0) begin
         status = isaq_pkg::ST_NO_QUOTA;
      end else if (conflict) begin
         status = isaq_pkg::ST_CONFLICT;
      end else begin
         upd.take = 1'b1;
         status   = isaq_pkg::ST_OK;
      end
   end

   assign map_next  = upd.take ? (map | mask) : map;
   assign free_next = upd.take ? FREE_W'(diff) : free;

   assign rsp.accepted        = upd.take;
   assign rsp.status_code     = status;
   assign rsp.free_slot_count = 5'(free_next);
   assign rsp.occupancy_map   = 24'(map_next);

endmodule

FILE: rtl/core/interval_slot_allocator_with_quotas_unit.sv
// ----------------------------------------------------------------------------
// Interval slot allocator with per-category quotas
// Request and result channels use valid/ready. Each request transfer either
// loads a category quota or reserves hour slots [start_hour, end_hour) of the
// day for a category; every request yields exactly one result transfer with
// status, free slot count and occupancy map after that request.
// An accepted request passes through the input register, then the result
// register, before it is offered on rsp_valid.
// Throughput: one request per cycle unless the receiver stalls; the quota table
// read at acceptance and the check/update between the two registers set it.
// A write to the same category by the item ahead is forwarded to the read.
// While the receiver stalls the result register holds and the input register
// still takes one more request; req_ready drops only when both are full.
// Reset clears the map, sets the free count to NUM_SLOTS and marks every quota
// entry unwritten (reads as zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "interval_slot_allocator_with_quotas_unit_defines.svh"

module interval_slot_allocator_with_quotas_unit #(
   parameter int NUM_SLOTS      = 24,
   parameter int NUM_CATEGORIES = 16,
   parameter int QUOTA_WIDTH    = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  isaq_pkg::req_type_t_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output isaq_pkg::rsp_type        rsp_data
);

   localparam int FREE_W = $clog2(NUM_SLOTS + 1);
   localparam int IDX_W  = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

   logic                     in_vld_ff;
   isaq_pkg::req_type_t_type in_req_ff;
   logic [QUOTA_WIDTH-1:0]   in_quota_ff;
   logic                     rsp_vld_ff;
   isaq_pkg::rsp_type        rsp_ff;
   logic [NUM_SLOTS-1:0]     map_ff;
   logic [FREE_W-1:0]        free_ff;
   logic [NUM_CATEGORIES-1:0] quota_vld_ff;
   logic [QUOTA_WIDTH-1:0]   quota_mem [NUM_CATEGORIES];

   logic                     advance;
   logic                     req_fire;
   logic [IDX_W-1:0]         rd_idx;
   logic [IDX_W-1:0]         wr_idx;
   logic                     wr_en;
   logic [QUOTA_WIDTH-1:0]   wr_data;
   isaq_pkg::rsp_type        rsp_in;
   isaq_pkg::upd_type        upd;
   logic [NUM_SLOTS-1:0]     map_in;
   logic [FREE_W-1:0]        free_in;

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign rd_idx  = IDX_W'(req_data.category_id - 5'd1);
   assign wr_idx  = IDX_W'(in_req_ff.category_id - 5'd1);
   assign wr_en   = advance && (upd.take || upd.load);
   assign wr_data = upd.load ? QUOTA_WIDTH'(in_req_ff.quota_value)
                             : (in_quota_ff - QUOTA_WIDTH'(1));

   isaq_eval #(
      .NUM_SLOTS      (NUM_SLOTS),
      .NUM_CATEGORIES (NUM_CATEGORIES),
      .QUOTA_WIDTH    (QUOTA_WIDTH),
      .FREE_W         (FREE_W)
   ) u_eval (
      .req       (in_req_ff),
      .quota_rd  (in_quota_ff),
      .map       (map_ff),
      .free      (free_ff),
      .rsp       (rsp_in),
      .upd       (upd),
      .map_next  (map_in),
      .free_next (free_in)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         map_ff       <= '0;
         free_ff      <= FREE_W'(NUM_SLOTS);
         quota_vld_ff <= '0;
      end else begin
         if (req_fire) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
            map_ff     <= map_in;
            free_ff    <= free_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
         if (wr_en) begin
            quota_vld_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // payload: input register with quota read, result register, quota table
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_req_ff <= req_data;
         if (wr_en && (wr_idx == rd_idx)) begin
            in_quota_ff <= wr_data;
         end else if (quota_vld_ff[rd_idx]) begin
            in_quota_ff <= quota_mem[rd_idx];
         end else begin
            in_quota_ff <= '0;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      if (wr_en) begin
         quota_mem[wr_idx] <= wr_data;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `ISAQ_ASSERT(a_free_tracks_map, ($countones(map_ff) + int'(free_ff)) == NUM_SLOTS, "free count out of step with map")
   `ISAQ_ASSERT(a_map_only_grows, 1'b1 |=> ((map_ff & $past(map_ff)) == $past(map_ff)), "slot released")
   `ISAQ_ASSERT(a_accept_means_ok, rsp_valid |-> (rsp_data.accepted == (rsp_data.status_code == isaq_pkg::ST_OK)), "accepted flag and status disagree")
   `ISAQ_ASSERT_ALWAYS(a_ready_when_empty, !in_vld_ff |-> req_ready, "ready low with empty input register")

endmodule
